// ===== design/abft_pkg.sv =====
`default_nettype none

package abft_pkg;

  // largest payload a request may carry
  localparam int unsigned MaxPayload = 16;

  // a start item with an empty payload gives the most results: five header bytes and the checksum
  localparam int unsigned MaxResults = 6;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegTimeoutTicks = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSourceAddr   = 1'b1;

  typedef enum logic [1:0] {
    CmdStart   = 2'd0,
    CmdPayload = 2'd1,
    CmdTick    = 2'd2,
    CmdRxByte  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadSize  = 3'd1,
    StTimeout  = 3'd2,
    StBadReply = 3'd3,
    StChecksum = 3'd4
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic       drive_select;
    logic       busy_led;
    logic       run_last;
  } result_t;

endpackage

`default_nettype wire

// ===== design/abft_res_buf.sv =====
`default_nettype none

module abft_res_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic [abft_pkg::CntW-1:0] load_cnt_i,
  input  wire abft_pkg::result_t load_res_i [abft_pkg::MaxResults],
  output logic                   free_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output abft_pkg::result_t      res_o
);
  import abft_pkg::*;

  result_t         slot_q [MaxResults];
  logic [CntW-1:0] cnt_q;
  logic            take;

  assign valid_o = (cnt_q != '0);
  assign take    = valid_o & ready_i;
  assign res_o   = slot_q[0];
  // free when empty or when the last result leaves in this cycle
  assign free_o  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= load_cnt_i;
    end else if (take) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // head is slot 0, later results shift down as the head is taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= load_res_i;
    end else if (take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxResults))
    else $error("result count out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("results loaded over pending results");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && load_cnt_i != '0) |=> valid_o)
    else $error("loaded results not presented");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cnt_q == CntW'(1) && !load_i) |=> !valid_o)
    else $error("result presented after drain");

endmodule

`default_nettype wire

// ===== design/aux_bus_frame_transceiver_unit.sv =====
// channel   dir  handshake                      payload
// cfg       in   cfg_we_i                       cfg_index_i, cfg_data_i
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata, tuser (command), tlast (burst end)
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata, tuser (kind), tlast (run last)
//
// an item is worked in the cycle it is accepted; state updates at that edge and its
// results (0 to 6) load a result register that drains one per cycle while
// m_axis_tready is high; an item producing several results holds the input until
// its last result leaves; single-result and silent items go at one per cycle unstalled
// s_axis_tready is high when the result register is empty or its last result leaves
// reset clears the phase, counters and sums and sets timeout 200, source address 13
`default_nettype none

module aux_bus_frame_transceiver_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [abft_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [abft_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // dest_address, message_id, payload_size, data_byte, select_level, zero fill
  input  wire logic [abft_pkg::InTdataW-1:0]  s_axis_tdata,
  // command
  input  wire logic [1:0]                     s_axis_tuser,
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tx_byte, status, drive_select, busy_led, zero fill
  output logic [abft_pkg::OutTdataW-1:0]      m_axis_tdata,
  // kind
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);
  import abft_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhSend,
    PhWaitLow,
    PhWaitHigh,
    PhRecv
  } phase_e;

  localparam logic [15:0] TimeoutReset = 16'd200;
  localparam logic [7:0]  SourceReset  = 8'd13;
  localparam logic [7:0]  Preamble     = 8'h3b;
  localparam logic [7:0]  PayloadLimit = 8'(MaxPayload);
  localparam logic [8:0]  RxLimit      = 9'(MaxPayload + 6);

  function automatic result_t mk_byte(logic [7:0] b, logic led);
    result_t r;
    r              = '0;
    r.tx_byte      = b;
    r.drive_select = 1'b1;
    r.busy_led     = led;
    return r;
  endfunction

  function automatic result_t mk_status(status_e st);
    result_t r;
    r        = '0;
    r.kind   = 1'b1;
    r.status = st;
    return r;
  endfunction

  logic [15:0] timeout_q;
  logic [7:0]  source_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  payload_left_q, payload_left_d;
  logic [7:0]  tx_sum_q, tx_sum_d;
  logic [15:0] wait_q, wait_d;
  logic [7:0]  rx_count_q, rx_count_d;
  logic [7:0]  rx_length_q, rx_length_d;
  logic [7:0]  rx_sum_q, rx_sum_d;
  logic [7:0]  rx_check_q, rx_check_d;
  logic        rx_seen_q, rx_seen_d;

  cmd_e        cmd;
  logic [7:0]  dest, msg_id, size, data;
  logic        sel, burst_end, accept, buf_free;
  logic [7:0]  len_byte, hdr_sum, pay_sum, len_new;
  logic [8:0]  rx_next;

  result_t         res   [MaxResults];
  logic [CntW-1:0] n_res;
  result_t         head;

  assign cmd       = cmd_e'(s_axis_tuser);
  assign dest      = s_axis_tdata[7:0];
  assign msg_id    = s_axis_tdata[15:8];
  assign size      = s_axis_tdata[23:16];
  assign data      = s_axis_tdata[31:24];
  assign sel       = s_axis_tdata[32];
  assign burst_end = s_axis_tlast;

  assign s_axis_tready = buf_free;
  assign accept        = s_axis_tvalid & buf_free;

  assign len_byte = size + 8'd3;
  assign hdr_sum  = len_byte + source_q + dest + msg_id;
  assign pay_sum  = tx_sum_q + data;
  assign len_new  = (rx_count_q == 8'd1) ? data : rx_length_q;
  assign rx_next  = {1'b0, rx_count_q} + 9'd1;

  always_comb begin
    phase_d        = phase_q;
    payload_left_d = payload_left_q;
    tx_sum_d       = tx_sum_q;
    wait_d         = wait_q;
    rx_count_d     = rx_count_q;
    rx_length_d    = rx_length_q;
    rx_sum_d       = rx_sum_q;
    rx_check_d     = rx_check_q;
    rx_seen_d      = rx_seen_q;
    n_res          = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end

    case (cmd)
      CmdStart: begin
        if (size > PayloadLimit) begin
          res[0]  = mk_status(StBadSize);
          n_res   = CntW'(1);
          phase_d = PhIdle;
        end else begin
          res[0]         = mk_byte(Preamble, 1'b0);
          res[1]         = mk_byte(len_byte, 1'b0);
          res[2]         = mk_byte(source_q, 1'b0);
          res[3]         = mk_byte(dest, 1'b0);
          res[4]         = mk_byte(msg_id, 1'b0);
          n_res          = CntW'(5);
          tx_sum_d       = hdr_sum;
          payload_left_d = size;
          phase_d        = PhSend;
          if (size == 8'd0) begin
            res[5]  = mk_byte(8'd0 - hdr_sum, 1'b1);
            n_res   = CntW'(6);
            phase_d = PhWaitLow;
            wait_d  = '0;
          end
        end
      end
      CmdPayload: begin
        if (phase_q == PhSend) begin
          res[0]         = mk_byte(data, 1'b0);
          n_res          = CntW'(1);
          tx_sum_d       = pay_sum;
          payload_left_d = payload_left_q - 8'd1;
          if (payload_left_q == 8'd1) begin
            res[1]  = mk_byte(8'd0 - pay_sum, 1'b1);
            n_res   = CntW'(2);
            phase_d = PhWaitLow;
            wait_d  = '0;
          end
        end
      end
      CmdTick: begin
        if (phase_q == PhWaitLow || phase_q == PhWaitHigh) begin
          if (wait_q != '1) begin
            wait_d = wait_q + 16'd1;
          end
          if (phase_q == PhWaitLow && !sel) begin
            phase_d = PhWaitHigh;
          end else if (phase_q == PhWaitHigh && sel) begin
            phase_d     = PhRecv;
            rx_count_d  = '0;
            rx_length_d = '0;
            rx_sum_d    = '0;
            rx_check_d  = '0;
            rx_seen_d   = 1'b0;
          end else if (wait_d > timeout_q) begin
            res[0]  = mk_status(StTimeout);
            n_res   = CntW'(1);
            phase_d = PhIdle;
          end
        end
      end
      CmdRxByte: begin
        if (phase_q == PhRecv) begin
          rx_length_d = len_new;
          // bytes from the length byte through the last payload byte are summed
          if (rx_count_q != 8'd0 && {1'b0, rx_count_q} <= {1'b0, len_new} + 9'd1) begin
            rx_sum_d = rx_sum_q + data;
          end
          if (rx_count_q >= 8'd2 && {1'b0, rx_count_q} == {1'b0, len_new} + 9'd2) begin
            rx_check_d = data;
            rx_seen_d  = 1'b1;
          end
          if (rx_next >= RxLimit) begin
            res[0]  = mk_status(StBadReply);
            n_res   = CntW'(1);
            phase_d = PhIdle;
          end else begin
            rx_count_d = rx_next[7:0];
            if (burst_end) begin
              n_res   = CntW'(1);
              phase_d = PhIdle;
              if (rx_next[7:0] <= 8'd6) begin
                res[0] = mk_status(StBadReply);
              end else if (!rx_seen_d) begin
                res[0] = mk_status(StChecksum);
              end else if (8'(8'd0 - rx_sum_d) != rx_check_d) begin
                res[0] = mk_status(StChecksum);
              end else begin
                res[0] = mk_status(StOk);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < MaxResults; i++) begin
      res[i].run_last = (n_res == CntW'(i + 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      source_q  <= SourceReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegTimeoutTicks: timeout_q <= cfg_data_i;
        RegSourceAddr:   source_q  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      payload_left_q <= '0;
      tx_sum_q       <= '0;
      wait_q         <= '0;
      rx_count_q     <= '0;
      rx_length_q    <= '0;
      rx_sum_q       <= '0;
      rx_check_q     <= '0;
      rx_seen_q      <= 1'b0;
    end else if (accept) begin
      phase_q        <= phase_d;
      payload_left_q <= payload_left_d;
      tx_sum_q       <= tx_sum_d;
      wait_q         <= wait_d;
      rx_count_q     <= rx_count_d;
      rx_length_q    <= rx_length_d;
      rx_sum_q       <= rx_sum_d;
      rx_check_q     <= rx_check_d;
      rx_seen_q      <= rx_seen_d;
    end
  end

  abft_res_buf u_res_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .load_cnt_i (n_res),
    .load_res_i (res),
    .free_o     (buf_free),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (head)
  );

  assign m_axis_tdata = {3'b000, head.busy_led, head.drive_select, head.status, head.tx_byte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.run_last;

  a_led_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && head.busy_led) |-> (head.drive_select && !head.kind))
    else $error("busy led on a result that is not a transmitted byte");

  a_checksum_ends_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PhSend && cmd == CmdPayload && payload_left_q == 8'd1)
      |=> phase_q == PhWaitLow && wait_q == '0)
    else $error("last payload byte did not start the handshake wait");

  a_wait_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && wait_q == '1 && cmd == CmdTick && phase_q == PhWaitHigh && !sel)
      |=> (wait_q == '1 || phase_q == PhIdle))
    else $error("wait count wrapped");

endmodule

`default_nettype wire

// ===== tb/sv/tb_aux_bus_frame_transceiver_unit.sv =====
`default_nettype none

module tb_aux_bus_frame_transceiver_unit;
  import abft_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 150;
  localparam logic [7:0] FramePreamble = 8'h3b;

  typedef enum logic [2:0] {
    LinkIdle,
    LinkSend,
    LinkWaitLow,
    LinkWaitHigh,
    LinkRecv
  } link_ph_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] dest;
    logic [7:0] id;
    logic [7:0] size;
    logic [7:0] data;
    logic       sel;
    logic       burst_end;
  } frame_req_t;

  typedef struct {
    frame_req_t rq;
    int         n_typed;
    result_t    typed;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  aux_bus_frame_transceiver_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // link state mirrored by the predictor
  logic [15:0] tmo_ticks   = 16'd200;
  logic [7:0]  src_addr    = 8'd13;
  link_ph_e    link_ph     = LinkIdle;
  logic [7:0]  pay_left    = '0;
  logic [7:0]  tx_sum      = '0;
  logic [15:0] tick_cnt    = '0;
  logic [7:0]  rx_cnt      = '0;
  logic [7:0]  rx_len      = '0;
  logic [7:0]  rx_sum      = '0;
  logic [7:0]  rx_chk      = '0;
  logic        rx_chk_seen = 1'b0;

  result_t  step_res [$];
  result_t  want_q [$];
  result_t  head_res;
  dir_row_t dir_rows [$];

  int  mismatches;
  int  results_seen;
  int  items_done;
  int  frames_started;
  int  st_hits [5];
  int  idle_cycles;
  int  hold_req;
  bit  fast_mode;

  task automatic report_mismatch(input string what, input int got, input int want_v);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want_v);
  endtask

  function automatic void emit_byte(input logic [7:0] b, input logic led);
    result_t r;
    r = '0;
    r.tx_byte = b;
    r.drive_select = 1'b1;
    r.busy_led = led;
    step_res.push_back(r);
  endfunction

  function automatic void add_tx(input logic [7:0] b);
    emit_byte(b, 1'b0);
    tx_sum = tx_sum + b;
  endfunction

  function automatic void add_check();
    logic [7:0] chk;
    chk = 8'd0 - tx_sum;
    emit_byte(chk, 1'b1);
    link_ph = LinkWaitLow;
    tick_cnt = '0;
  endfunction

  function automatic void close_link(input status_e st);
    result_t r;
    r = '0;
    r.kind = 1'b1;
    r.status = st;
    step_res.push_back(r);
    st_hits[int'(st)]++;
    link_ph = LinkIdle;
  endfunction

  function automatic result_t status_only(input status_e st);
    result_t r;
    r = '0;
    r.kind = 1'b1;
    r.status = st;
    r.run_last = 1'b1;
    return r;
  endfunction

  // works out the results of one item; returns 1 if the item was not ignored
  function automatic bit predict_frame(input frame_req_t rq);
    int idx;
    bit live;
    logic [7:0] neg_sum;
    step_res.delete();
    live = 1'b0;
    case (rq.cmd)
      CmdStart: begin
        live = 1'b1;
        if (rq.size > MaxPayload) begin
          close_link(StBadSize);
        end else begin
          frames_started++;
          tx_sum = '0;
          emit_byte(FramePreamble, 1'b0);
          add_tx(rq.size + 8'd3);
          add_tx(src_addr);
          add_tx(rq.dest);
          add_tx(rq.id);
          pay_left = rq.size;
          link_ph = LinkSend;
          if (pay_left == 8'd0) add_check();
        end
      end
      CmdPayload: begin
        if (link_ph == LinkSend) begin
          live = 1'b1;
          add_tx(rq.data);
          pay_left = pay_left - 8'd1;
          if (pay_left == 8'd0) add_check();
        end
      end
      CmdTick: begin
        if (link_ph == LinkWaitLow || link_ph == LinkWaitHigh) begin
          live = 1'b1;
          if (tick_cnt != 16'hffff) tick_cnt = tick_cnt + 16'd1;
          // select level wins over the timeout test
          if (link_ph == LinkWaitLow && !rq.sel) begin
            link_ph = LinkWaitHigh;
          end else if (link_ph == LinkWaitHigh && rq.sel) begin
            link_ph = LinkRecv;
            rx_cnt = '0;
            rx_len = '0;
            rx_sum = '0;
            rx_chk = '0;
            rx_chk_seen = 1'b0;
          end else if (tick_cnt > tmo_ticks) begin
            close_link(StTimeout);
          end
        end
      end
      default: begin
        if (link_ph == LinkRecv) begin
          live = 1'b1;
          idx = int'(rx_cnt);
          if (idx == 1) rx_len = rq.data;
          if (idx >= 1 && idx <= int'(rx_len) + 1) rx_sum = rx_sum + rq.data;
          if (idx >= 2 && idx == int'(rx_len) + 2) begin
            rx_chk = rq.data;
            rx_chk_seen = 1'b1;
          end
          if (idx + 1 >= int'(MaxPayload) + 6) begin
            close_link(StBadReply);
          end else begin
            rx_cnt = 8'(idx + 1);
            neg_sum = 8'd0 - rx_sum;
            if (rq.burst_end) begin
              if (rx_cnt <= 8'd6) close_link(StBadReply);
              else if (!rx_chk_seen) close_link(StChecksum);
              else if (neg_sum != rx_chk) close_link(StChecksum);
              else close_link(StOk);
            end
          end
        end
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
    return live;
  endfunction

  function automatic frame_req_t noise_req();
    frame_req_t rq;
    rq.cmd = cmd_e'($urandom_range(0, 3));
    rq.dest = 8'($urandom);
    rq.id = 8'($urandom);
    rq.size = 8'($urandom);
    rq.data = 8'($urandom);
    rq.sel = 1'($urandom);
    rq.burst_end = 1'($urandom);
    return rq;
  endfunction

  function automatic frame_req_t mk_req(input cmd_e c, input logic [7:0] dest, input logic [7:0] id,
                                        input logic [7:0] size, input logic [7:0] data,
                                        input logic sel, input logic last);
    frame_req_t rq;
    rq.cmd = c;
    rq.dest = dest;
    rq.id = id;
    rq.size = size;
    rq.data = data;
    rq.sel = sel;
    rq.burst_end = last;
    return rq;
  endfunction

  function automatic void add_row(input frame_req_t rq, input int n_typed = -1,
                                  input result_t typed = '0);
    dir_row_t row;
    row.rq = rq;
    row.n_typed = n_typed;
    row.typed = typed;
    dir_rows.push_back(row);
  endfunction

  // drives one item and returns at the edge where it is taken
  task automatic offer_item(input frame_req_t rq, input int n_typed = -1,
                            input result_t typed = '0);
    int gap;
    bit live;
    gap = fast_mode ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.cmd;
    s_axis_tlast  <= rq.burst_end;
    s_axis_tdata  <= {7'd0, rq.sel, rq.data, rq.size, rq.id, rq.dest};
    live = predict_frame(rq);
    if (n_typed >= 0) begin
      step_res.delete();
      if (n_typed > 0) step_res.push_back(typed);
    end
    foreach (step_res[k]) want_q.push_back(step_res[k]);
    if (live) items_done++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] tmo, input logic [7:0] src);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegTimeoutTicks;
    cfg_data_i  <= tmo;
    @(posedge clk_i);
    cfg_index_i <= RegSourceAddr;
    cfg_data_i  <= {8'd0, src};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tmo_ticks = tmo;
    src_addr = src;
  endtask

  task automatic send_reply();
    frame_req_t rq;
    logic [7:0] rbytes [0:31];
    logic [7:0] csum;
    int style;
    int len;
    int nb;
    style = $urandom_range(0, 9);
    len = $urandom_range(4, 18);
    if (style == 7 && len < 5) len = 5;
    for (int k = 0; k < 32; k++) rbytes[k] = 8'($urandom);
    if ($urandom_range(0, 7) != 0) rbytes[0] = FramePreamble;
    rbytes[1] = 8'(len);
    csum = '0;
    for (int k = 1; k <= len + 1; k++) csum = csum + rbytes[k];
    rbytes[len + 2] = 8'd0 - csum;
    nb = len + 3;
    case (style)
      6: rbytes[len + 2] = rbytes[len + 2] ^ 8'($urandom_range(1, 255));
      7: nb = $urandom_range(7, len + 2);   // burst ends before the checksum byte
      8: nb = $urandom_range(1, 6);
      9: nb = 24;                           // runs past the reply size limit
      default: ;
    endcase
    for (int k = 0; k < nb; k++) begin
      rq = noise_req();
      rq.cmd = CmdRxByte;
      rq.data = rbytes[k];
      rq.burst_end = (style == 9) ? 1'b0 : (k == nb - 1);
      offer_item(rq);
    end
  endtask

  // one request frame, its handshake wait and the reply, with some noise
  task automatic run_exchange();
    frame_req_t rq;
    int guard;
    bit timeout_try;
    logic awaited;
    fast_mode = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) offer_item(noise_req());
    end
    rq = noise_req();
    rq.cmd = CmdStart;
    case ($urandom_range(0, 9))
      0: rq.size = 8'($urandom_range(MaxPayload + 1, 255));
      1: rq.size = 8'(MaxPayload);
      default: rq.size = 8'($urandom_range(0, 6));
    endcase
    offer_item(rq);
    while (link_ph == LinkSend) begin
      rq = noise_req();
      if ($urandom_range(0, 40) == 0) begin
        // restart in the middle of a frame
        rq.cmd = CmdStart;
        rq.size = 8'($urandom_range(0, MaxPayload));
      end else begin
        rq.cmd = CmdPayload;
      end
      offer_item(rq);
    end
    timeout_try = (tmo_ticks <= 16'd40) && ($urandom_range(0, 3) == 0);
    guard = 0;
    while ((link_ph == LinkWaitLow || link_ph == LinkWaitHigh) && guard < 300) begin
      rq = noise_req();
      awaited = (link_ph == LinkWaitHigh);
      if ($urandom_range(0, 11) == 0) begin
        rq.cmd = CmdRxByte;
      end else begin
        rq.cmd = CmdTick;
        rq.sel = (!timeout_try && $urandom_range(0, 2) == 0) ? awaited : !awaited;
      end
      offer_item(rq);
      guard++;
    end
    if (link_ph == LinkRecv) send_reply();
    if ($urandom_range(0, 11) == 0) settle();
  endtask

  // result side: random back-pressure, with one long hold on request
  initial begin
    int rgap;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req > 0) begin
        rgap = hold_req;
        hold_req = 0;
      end else begin
        rgap = fast_mode ? 0 : $urandom_range(0, 17);
      end
      if (rgap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rgap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (want_q.size() == 0) begin
        report_mismatch("result with nothing pending", int'(m_axis_tdata), 0);
      end else begin
        head_res = want_q.pop_front();
        if (m_axis_tuser[0] != head_res.kind)
          report_mismatch("kind", m_axis_tuser[0], head_res.kind);
        if (m_axis_tdata[7:0] != head_res.tx_byte)
          report_mismatch("tx_byte", m_axis_tdata[7:0], head_res.tx_byte);
        if (m_axis_tdata[10:8] != head_res.status)
          report_mismatch("status", m_axis_tdata[10:8], head_res.status);
        if (m_axis_tdata[11] != head_res.drive_select)
          report_mismatch("drive_select", m_axis_tdata[11], head_res.drive_select);
        if (m_axis_tdata[12] != head_res.busy_led)
          report_mismatch("busy_led", m_axis_tdata[12], head_res.busy_led);
        if (m_axis_tlast != head_res.run_last)
          report_mismatch("run_last", m_axis_tlast, head_res.run_last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("no handshake for %0d cycles, %0d results pending", idle_cycles, want_q.size());
      $display("aux_bus_frame_transceiver_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int target;
    logic [15:0] tmo_set [4];
    logic [7:0]  src_set [4];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    fast_mode = 1'b0;
    hold_req = 0;
    idle_cycles = 0;

    tmo_set[0] = 16'd1;
    src_set[0] = 8'h00;
    tmo_set[1] = 16'hffff;
    src_set[1] = 8'hff;
    tmo_set[2] = 16'($urandom_range(2, 12));
    src_set[2] = 8'($urandom);
    tmo_set[3] = 16'($urandom_range(13, 40));
    src_set[3] = 8'h5a;

    // out-of-phase items are dropped after reset
    add_row(mk_req(CmdPayload, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1), 0);
    add_row(mk_req(CmdTick,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0), 0);
    add_row(mk_req(CmdRxByte,  8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 1'b1), 0);
    // oversized starts
    add_row(mk_req(CmdStart, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1), 1,
            status_only(StBadSize));
    add_row(mk_req(CmdStart, 8'h00, 8'h00, 8'(MaxPayload + 1), 8'h00, 1'b0, 1'b0), 1,
            status_only(StBadSize));
    // empty payload: header and checksum in one item
    add_row(mk_req(CmdStart, 8'hff, 8'hff, 8'h00, 8'h00, 1'b0, 1'b0));
    add_row(mk_req(CmdTick,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    add_row(mk_req(CmdTick,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    add_row(mk_req(CmdTick,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    // six byte reply is too short
    add_row(mk_req(CmdRxByte, 8'h00, 8'h00, 8'h00, 8'h3b, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte, 8'h00, 8'h00, 8'h00, 8'h03, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1), 1,
            status_only(StBadReply));
    // one payload byte, then a well-formed reply
    add_row(mk_req(CmdStart,   8'h00, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0));
    add_row(mk_req(CmdPayload, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b0));
    add_row(mk_req(CmdTick,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    add_row(mk_req(CmdTick,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    add_row(mk_req(CmdRxByte,  8'h00, 8'h00, 8'h00, 8'h3b, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte,  8'h00, 8'h00, 8'h00, 8'h04, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte,  8'h00, 8'h00, 8'h00, 8'h0a, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte,  8'h00, 8'h00, 8'h00, 8'h0b, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte,  8'h00, 8'h00, 8'h00, 8'h0c, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte,  8'h00, 8'h00, 8'h00, 8'h0d, 1'b0, 1'b0));
    add_row(mk_req(CmdRxByte,  8'h00, 8'h00, 8'h00, 8'hce, 1'b0, 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) offer_item(dir_rows[r].rq, dir_rows[r].n_typed, dir_rows[r].typed);

    for (int p = 0; p < 4; p++) begin
      settle();
      program_regs(tmo_set[p], src_set[p]);
      // long stall on the result side while items keep coming
      if (p == 1) hold_req = HoldCycles;
      target = items_done + 75;
      while (items_done < target) run_exchange();
    end

    settle();
    repeat (6) @(posedge clk_i);

    $display("covered %0d items that took effect, %0d results checked, %0d frames sent",
             items_done, results_seen, frames_started);
    $display("completions: ok %0d, bad size %0d, timeout %0d, bad reply %0d, checksum %0d",
             st_hits[0], st_hits[1], st_hits[2], st_hits[3], st_hits[4]);
    if (mismatches == 0) begin
      $display("aux_bus_frame_transceiver_unit verification clean");
    end else begin
      $display("aux_bus_frame_transceiver_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
